/* rtl/oracle_merge_sort_sequencer_core_defines.svh */
// Assertion helpers for the sequencer core.
`ifndef ORACLE_MERGE_SORT_SEQUENCER_CORE_DEFINES_SVH
`define ORACLE_MERGE_SORT_SEQUENCER_CORE_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define OMS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Condition that must hold whenever the antecedent holds.
`define OMS_ASSERT_IMP(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/oms_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package oms_pkg;

  localparam int unsigned LabelW          = 5;
  localparam int unsigned LabelSpace      = 32;
  localparam int unsigned StackSlots      = 6;
  localparam int unsigned StackW          = 3;
  localparam int unsigned MaxItemsDefault = 32;

  // Input transaction.
  typedef struct packed {
    logic       op;
    logic [5:0] count;
    logic       left_is_less;
  } oms_in_t;

  // Output transaction.
  typedef struct packed {
    logic              kind;
    logic [LabelW-1:0] query_left;
    logic [LabelW-1:0] query_right;
    logic [LabelW-1:0] sorted_label;
    logic              last;
  } oms_out_t;

  typedef enum logic {
    OP_START  = 1'b0,
    OP_ANSWER = 1'b1
  } oms_op_e;

  typedef enum logic {
    KIND_QUERY = 1'b0,
    KIND_LABEL = 1'b1
  } oms_kind_e;

  typedef enum logic [1:0] {
    PH_LEFT,
    PH_RIGHT,
    PH_MERGE
  } oms_phase_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_DRIVE,
    S_CRD,
    S_CWR,
    S_NEXT,
    S_QOUT,
    S_WAIT,
    S_TRD,
    S_TWR,
    S_ERD,
    S_EOUT
  } oms_state_e;

endpackage

`default_nettype wire

/* rtl/oms_mem.sv */
`timescale 1ns / 1ps
`default_nettype none

module oms_mem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5,
  parameter int unsigned DW    = 5
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/oracle_merge_sort_sequencer_core.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "oracle_merge_sort_sequencer_core_defines.svh"

// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_stall_o | in_data_i  (op, count, left_is_less)
// out     | output    | out_valid_o/ out_stall_i| out_data_o (kind, labels, last)
//
// A start loads the identity order into the label memory, then walks the
// range stack until the first query. An answer writes the chosen label and
// the run heads are read before the next query; when a run empties, its tail
// is copied into the label memory, and the next merge copies its range into
// the two run memories, all through the one write port of each memory.
// Sorted labels leave one at a time. Reset clears the control state only;
// the memories need no clearing. A stalled output holds the sequencer.

module oracle_merge_sort_sequencer_core #(
  parameter int unsigned MAX_ITEMS = oms_pkg::MaxItemsDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire oms_pkg::oms_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output oms_pkg::oms_out_t     out_data_o
);

  import oms_pkg::*;

  localparam int unsigned Depth = (MAX_ITEMS < LabelSpace) ? MAX_ITEMS : LabelSpace;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW    = AW + 1;

  typedef struct packed {
    logic [AW-1:0] lo;
    logic [AW-1:0] hi;
    oms_phase_e    phase;
  } range_t;

  oms_state_e        state_q, state_d;
  range_t            stack_q [StackSlots];
  range_t            stack_d [StackSlots];
  logic [StackW-1:0] sp_q, sp_d, tix;
  logic [CW-1:0]     n_q, n_d, cnt_q, cnt_d, li_q, li_d, ri_q, ri_d, oidx_q, oidx_d;
  logic [LabelW-1:0] ql_q, ql_d, qr_q, qr_d;
  logic              out_valid_q, out_valid_d;
  oms_out_t          out_q, out_d;

  range_t            top;
  logic [AW-1:0]     mid;
  logic [CW-1:0]     ll, rl, total, rofs;
  logic              in_acc, out_free, push_left, push_right;

  logic              lab_we, left_we, right_we;
  logic [AW-1:0]     lab_wa, lab_ra, left_wa, right_wa;
  logic [LabelW-1:0] lab_wd, left_wd, right_wd, lab_rd, left_rd, right_rd;

  // Top of the range stack and the split of its range.
  assign tix        = sp_q - 1'b1;
  assign top        = (sp_q != '0) ? stack_q[tix] : '0;
  assign mid        = top.lo + AW'((top.hi - top.lo) >> 1);
  assign ll         = CW'(mid) - CW'(top.lo) + 1'b1;
  assign rl         = CW'(top.hi) - CW'(mid);
  assign total      = CW'(top.hi) - CW'(top.lo);
  assign rofs       = cnt_q - ll;
  assign push_left  = (mid > top.lo);
  assign push_right = (CW'(top.hi) > (CW'(mid) + 1'b1));

  // Handshakes.
  assign in_stall_o  = !((state_q == S_IDLE) || (state_q == S_WAIT));
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Memory read addresses follow registered indexes.
  assign lab_ra = ((state_q == S_CRD) || (state_q == S_CWR)) ?
                  (top.lo + cnt_q[AW-1:0]) : cnt_q[AW-1:0];

  oms_mem #(.DEPTH(Depth), .AW(AW), .DW(LabelW)) u_label (
    .clk_i, .we_i(lab_we), .waddr_i(lab_wa), .wdata_i(lab_wd),
    .raddr_i(lab_ra), .rdata_o(lab_rd)
  );

  oms_mem #(.DEPTH(Depth), .AW(AW), .DW(LabelW)) u_left (
    .clk_i, .we_i(left_we), .waddr_i(left_wa), .wdata_i(left_wd),
    .raddr_i(li_q[AW-1:0]), .rdata_o(left_rd)
  );

  oms_mem #(.DEPTH(Depth), .AW(AW), .DW(LabelW)) u_right (
    .clk_i, .we_i(right_we), .waddr_i(right_wa), .wdata_i(right_wd),
    .raddr_i(ri_q[AW-1:0]), .rdata_o(right_rd)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE, S_WAIT: begin
        if (in_acc) begin
          if (in_data_i.op == OP_START) begin
            state_d = S_INIT;
          end else if (state_q == S_WAIT) begin
            state_d = S_NEXT;
          end
        end
      end
      S_INIT: begin
        if (cnt_q == n_q - 1'b1) state_d = S_DRIVE;
      end
      S_DRIVE: begin
        if (sp_q == '0) begin
          state_d = S_ERD;
        end else if (top.phase == PH_MERGE) begin
          state_d = S_CRD;
        end
      end
      S_CRD: state_d = S_CWR;
      S_CWR: state_d = (cnt_q == total) ? S_NEXT : S_CRD;
      S_NEXT: state_d = ((li_q < ll) && (ri_q < rl)) ? S_QOUT : S_TRD;
      S_QOUT: begin
        if (out_free) state_d = S_WAIT;
      end
      S_TRD: state_d = ((li_q < ll) || (ri_q < rl)) ? S_TWR : S_DRIVE;
      S_TWR: state_d = S_TRD;
      S_ERD: state_d = S_EOUT;
      S_EOUT: begin
        if (out_free) state_d = (cnt_q == n_q - 1'b1) ? S_IDLE : S_ERD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    sp_d        = sp_q;
    stack_d     = stack_q;
    n_d         = n_q;
    cnt_d       = cnt_q;
    li_d        = li_q;
    ri_d        = ri_q;
    oidx_d      = oidx_q;
    ql_d        = ql_q;
    qr_d        = qr_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    lab_we      = 1'b0;
    lab_wa      = oidx_q[AW-1:0];
    lab_wd      = '0;
    left_we     = 1'b0;
    left_wa     = cnt_q[AW-1:0];
    left_wd     = lab_rd;
    right_we    = 1'b0;
    right_wa    = rofs[AW-1:0];
    right_wd    = lab_rd;
    unique case (state_q)
      S_IDLE, S_WAIT: begin
        if (in_acc) begin
          if (in_data_i.op == OP_START) begin
            // Clamp the count into one to the memory depth.
            if (in_data_i.count == '0) begin
              n_d = CW'(1);
            end else if (in_data_i.count > 6'(Depth)) begin
              n_d = CW'(Depth);
            end else begin
              n_d = CW'(in_data_i.count);
            end
            cnt_d = '0;
            sp_d  = '0;
          end else if (state_q == S_WAIT) begin
            // The answer picks the head of one run.
            lab_we = 1'b1;
            lab_wd = in_data_i.left_is_less ? ql_q : qr_q;
            oidx_d = oidx_q + 1'b1;
            if (in_data_i.left_is_less) begin
              li_d = li_q + 1'b1;
            end else begin
              ri_d = ri_q + 1'b1;
            end
          end
        end
      end
      S_INIT: begin
        lab_we = 1'b1;
        lab_wa = cnt_q[AW-1:0];
        lab_wd = LabelW'(cnt_q[AW-1:0]);
        cnt_d  = cnt_q + 1'b1;
        if ((cnt_q == n_q - 1'b1) && (n_q > CW'(1))) begin
          stack_d[0] = '{lo: '0, hi: AW'(n_q - 1'b1), phase: PH_LEFT};
          sp_d       = StackW'(1);
        end
      end
      S_DRIVE: begin
        if (sp_q == '0) begin
          cnt_d = '0;
        end else begin
          case (top.phase)
            PH_LEFT: begin
              stack_d[tix].phase = PH_RIGHT;
              if (push_left && (sp_q < StackW'(StackSlots))) begin
                stack_d[sp_q] = '{lo: top.lo, hi: mid, phase: PH_LEFT};
                sp_d          = sp_q + 1'b1;
              end
            end
            PH_RIGHT: begin
              stack_d[tix].phase = PH_MERGE;
              if (push_right && (sp_q < StackW'(StackSlots))) begin
                stack_d[sp_q] = '{lo: mid + 1'b1, hi: top.hi, phase: PH_LEFT};
                sp_d          = sp_q + 1'b1;
              end
            end
            default: cnt_d = '0;
          endcase
        end
      end
      S_CWR: begin
        // Split the range into the two run memories.
        if (cnt_q < ll) begin
          left_we = 1'b1;
        end else begin
          right_we = 1'b1;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == total) begin
          li_d   = '0;
          ri_d   = '0;
          oidx_d = CW'(top.lo);
        end
      end
      S_QOUT: begin
        if (out_free) begin
          ql_d        = left_rd;
          qr_d        = right_rd;
          out_valid_d = 1'b1;
          out_d       = '{kind: KIND_QUERY, query_left: left_rd, query_right: right_rd,
                          sorted_label: '0, last: 1'b0};
        end
      end
      S_TRD: begin
        if (!((li_q < ll) || (ri_q < rl))) begin
          sp_d = sp_q - 1'b1;
        end
      end
      S_TWR: begin
        // Copy the remaining tail of whichever run is left.
        lab_we = 1'b1;
        oidx_d = oidx_q + 1'b1;
        if (li_q < ll) begin
          lab_wd = left_rd;
          li_d   = li_q + 1'b1;
        end else begin
          lab_wd = right_rd;
          ri_d   = ri_q + 1'b1;
        end
      end
      S_EOUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{kind: KIND_LABEL, query_left: '0, query_right: '0,
                          sorted_label: lab_rd, last: (cnt_q == n_q - 1'b1)};
          cnt_d       = cnt_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sp_q        <= '0;
      stack_q     <= '{default: '0};
      n_q         <= '0;
      cnt_q       <= '0;
      li_q        <= '0;
      ri_q        <= '0;
      oidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      stack_q     <= stack_d;
      n_q         <= n_d;
      cnt_q       <= cnt_d;
      li_q        <= li_d;
      ri_q        <= ri_d;
      oidx_q      <= oidx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    ql_q  <= ql_d;
    qr_q  <= qr_d;
    out_q <= out_d;
  end

  `OMS_ASSERT_ALWAYS(a_stack_bound, sp_q <= StackW'(StackSlots), "range stack overflow")
  `OMS_ASSERT_IMP(a_wait_runs, state_q == S_WAIT, (li_q < ll) && (ri_q < rl), "query with an empty run")
  `OMS_ASSERT_IMP(a_copy_range, state_q == S_CWR, cnt_q <= total, "copy beyond the range")

endmodule

`default_nettype wire

/* tb/sv/merge_sort_checker.sv */
`timescale 1ns / 1ps

// Watches both channels of the merge-sort sequencer, predicts every result
// from the accepted input transactions and compares field by field.
module merge_sort_checker #(
  parameter int unsigned MAX_ITEMS = oms_pkg::MaxItemsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_o,
  input  oms_pkg::oms_in_t in_data_i,
  input  logic             out_valid_o,
  input  logic             out_stall_i,
  input  oms_pkg::oms_out_t out_data_o,
  output int               pending_o,
  output int               fail_count_o
);
  import oms_pkg::*;

  localparam int unsigned Slots = StackSlots;

  // Predicted sequencer state.
  logic [LabelW-1:0] order_mem [LabelSpace];
  logic [LabelW-1:0] lrun_mem [LabelSpace];
  logic [LabelW-1:0] rrun_mem [LabelSpace];
  int unsigned       span_lo [Slots];
  int unsigned       span_hi [Slots];
  oms_phase_e        span_ph [Slots];
  int unsigned       depth;
  int unsigned       lpos, rpos, wpos;
  int unsigned       llen, rlen, nitems;
  bit                waiting;

  oms_out_t expected_q [$];

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  task automatic push_span(input int unsigned lo, input int unsigned hi);
    if (depth < Slots) begin
      span_lo[depth] = lo;
      span_hi[depth] = hi;
      span_ph[depth] = PH_LEFT;
      depth++;
    end
  endtask

  task automatic queue_query();
    oms_out_t q;
    q = '0;
    q.kind = KIND_QUERY;
    q.query_left = lrun_mem[lpos % LabelSpace];
    q.query_right = rrun_mem[rpos % LabelSpace];
    expected_q.push_back(q);
  endtask

  task automatic place_label(input logic [LabelW-1:0] v);
    order_mem[wpos % LabelSpace] = v;
    wpos++;
  endtask

  // Walks the range stack until a merge needs a comparison or the sort ends.
  task automatic advance_sort();
    int unsigned t, lo, hi, mid;
    oms_out_t    r;
    while (depth > 0) begin
      t = depth - 1;
      lo = span_lo[t];
      hi = span_hi[t];
      mid = lo + (hi - lo) / 2;
      if (span_ph[t] == PH_LEFT) begin
        span_ph[t] = PH_RIGHT;
        if (mid > lo) push_span(lo, mid);
      end else if (span_ph[t] == PH_RIGHT) begin
        span_ph[t] = PH_MERGE;
        if (hi > mid + 1) push_span(mid + 1, hi);
      end else begin
        llen = mid - lo + 1;
        rlen = hi - mid;
        for (int i = 0; i < llen; i++) lrun_mem[i % LabelSpace] = order_mem[(lo + i) % LabelSpace];
        for (int i = 0; i < rlen; i++)
          rrun_mem[i % LabelSpace] = order_mem[(mid + 1 + i) % LabelSpace];
        lpos = 0;
        rpos = 0;
        wpos = lo;
        waiting = 1'b1;
        queue_query();
        return;
      end
    end
    // Sort finished: the whole order goes out.
    for (int k = 0; k < nitems; k++) begin
      r = '0;
      r.kind = KIND_LABEL;
      r.sorted_label = order_mem[k % LabelSpace];
      r.last = (k + 1 == nitems);
      expected_q.push_back(r);
    end
    waiting = 1'b0;
  endtask

  task automatic predict(input oms_in_t t);
    int unsigned n;
    if (t.op == OP_START) begin
      n = 32'(t.count);
      if (n < 1) n = 1;
      if (n > MAX_ITEMS) n = MAX_ITEMS;
      if (n > LabelSpace) n = LabelSpace;
      nitems = n;
      for (int i = 0; i < n; i++) order_mem[i] = LabelW'(i);
      depth = 0;
      waiting = 1'b0;
      if (n >= 2) push_span(0, n - 1);
      advance_sort();
      return;
    end
    // An answer with no query open is dropped.
    if (!waiting) return;
    if (t.left_is_less) begin
      place_label(lrun_mem[lpos % LabelSpace]);
      lpos++;
    end else begin
      place_label(rrun_mem[rpos % LabelSpace]);
      rpos++;
    end
    if (lpos < llen && rpos < rlen) begin
      queue_query();
      return;
    end
    while (lpos < llen) begin
      place_label(lrun_mem[lpos % LabelSpace]);
      lpos++;
    end
    while (rpos < rlen) begin
      place_label(rrun_mem[rpos % LabelSpace]);
      rpos++;
    end
    waiting = 1'b0;
    if (depth > 0) depth--;
    advance_sort();
  endtask

  task automatic compare_result(input oms_out_t got);
    oms_out_t want;
    if (expected_q.size() == 0) begin
      report_mismatch("unexpected transaction, kind", int'(got.kind), -1);
      return;
    end
    want = expected_q.pop_front();
    if (got.kind !== want.kind) report_mismatch("kind", int'(got.kind), int'(want.kind));
    if (got.query_left !== want.query_left)
      report_mismatch("query_left", int'(got.query_left), int'(want.query_left));
    if (got.query_right !== want.query_right)
      report_mismatch("query_right", int'(got.query_right), int'(want.query_right));
    if (got.sorted_label !== want.sorted_label)
      report_mismatch("sorted_label", int'(got.sorted_label), int'(want.sorted_label));
    if (got.last !== want.last) report_mismatch("last", int'(got.last), int'(want.last));
  endtask

  initial fail_count_o = 0;

  // Results are checked before the input of the same edge is predicted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth = 0;
      lpos = 0;
      rpos = 0;
      wpos = 0;
      llen = 0;
      rlen = 0;
      nitems = 0;
      waiting = 1'b0;
      for (int i = 0; i < LabelSpace; i++) begin
        order_mem[i] = '0;
        lrun_mem[i] = '0;
        rrun_mem[i] = '0;
      end
      expected_q.delete();
    end else begin
      if (out_valid_o && !out_stall_i) compare_result(out_data_o);
      if (in_valid_i && !in_stall_o) predict(in_data_i);
    end
    pending_o = expected_q.size();
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

// Drives sort requests and oracle answers into the sequencer and gives the verdict.
module testbench;
  import oms_pkg::*;

  localparam int HoldCycles = 300;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  oms_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  oms_out_t out_data_o;
  int       pending;
  int       fail_count;

  bit       calm = 1'b0;
  bit       hold_req = 1'b0;
  int       sent = 0;
  int       sorts_done = 0;
  int       answers_sent = 0;
  int       keys [LabelSpace];
  oms_out_t seen_q [$];

  oracle_merge_sort_sequencer_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  merge_sort_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .pending_o(pending), .fail_count_o(fail_count)
  );

  always #5 clk_i = ~clk_i;

  // The oracle side needs to see each transaction that leaves the block.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) seen_q.push_back(out_data_o);
  end

  // Receiver: random stall after each transaction, plus one long hold-off.
  initial begin
    int w;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
      end else if (out_valid_o && !out_stall_i) begin
        w = calm ? 0 : $urandom_range(0, 3);
        if (w > 0) begin
          out_stall_i <= 1'b1;
          repeat (w) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  // Offers one transaction after a random gap and returns once it is accepted.
  // Valid stays up afterwards so that a following transaction can go back to
  // back; whoever waits next drops it.
  task automatic send(input oms_op_e op, input logic [5:0] cnt, input logic lil);
    int g;
    g = calm ? 0 : $urandom_range(0, 3);
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{op: op, count: cnt, left_is_less: lil};
    do @(posedge clk_i); while (in_stall_o);
    sent++;
  endtask

  task automatic next_seen(output oms_out_t r);
    if (seen_q.size() == 0) begin
      in_valid_i <= 1'b0;
      while (seen_q.size() == 0) @(posedge clk_i);
    end
    r = seen_q.pop_front();
  endtask

  // One sort. Mode 0 answers from random keys, 1 always left, 2 always right,
  // 3 at random. A non-negative stop_after abandons the sort after that many
  // answers, leaving the block waiting.
  task automatic run_sort(input logic [5:0] cnt, input int mode, input int stop_after);
    oms_out_t r;
    logic     lil;
    int       answered;
    answered = 0;
    for (int i = 0; i < LabelSpace; i++) keys[i] = $urandom_range(0, 40);
    send(OP_START, cnt, 1'($urandom_range(0, 1)));
    forever begin
      next_seen(r);
      if (r.kind == KIND_LABEL) begin
        if (r.last) break;
      end else begin
        if (answered == stop_after) return;
        case (mode)
          0: lil = keys[r.query_left] < keys[r.query_right];
          1: lil = 1'b1;
          2: lil = 1'b0;
          default: lil = 1'($urandom_range(0, 1));
        endcase
        send(OP_ANSWER, 6'($urandom_range(0, 63)), lil);
        answered++;
        answers_sent++;
      end
    end
    sorts_done++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    seen_q.delete();
  endtask

  initial begin
    int r, n, target, budget, stop;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: answers while idle, zero and single counts, small sizes,
    // one-sided answers, and an abandoned sort restarted while busy.
    send(OP_ANSWER, 6'd63, 1'b1);
    send(OP_ANSWER, 6'd0, 1'b0);
    run_sort(6'd0, 0, -1);
    run_sort(6'd1, 0, -1);
    run_sort(6'd2, 1, -1);
    run_sort(6'd2, 2, -1);
    run_sort(6'd3, 0, -1);
    run_sort(6'd63, 3, 2);
    run_sort(6'd5, 1, -1);
    drain();

    // Fill the block while the receiver holds off, then let it drain fully.
    hold_req = 1'b1;
    repeat (4) send(OP_START, 6'($urandom_range(1, 3)), 1'($urandom_range(0, 1)));
    send(OP_START, 6'd1, 1'b0);
    send(OP_ANSWER, 6'd17, 1'b1);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (hold_req) @(posedge clk_i);
    drain();

    // Random sorts, mostly small, with noise answers and abandoned runs. A sort
    // that would overrun the input budget is abandoned when the budget is spent.
    target = sent + 80;
    while (sent < target) begin
      calm = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 5) == 0) begin
        send(OP_ANSWER, 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
      end
      r = $urandom_range(0, 39);
      if (r == 0) n = 32;
      else if (r < 3) n = $urandom_range(33, 63);
      else if (r < 8) n = $urandom_range(9, 20);
      else n = $urandom_range(0, 8);
      budget = target - sent - 1;
      if (budget < 0) budget = 0;
      stop = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : -1;
      if ((stop < 0) || (stop > budget)) stop = budget;
      run_sort(6'(n), ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0, stop);
    end
    calm = 1'b0;
    drain();

    $display("Covered %0d completed sorts, %0d oracle answers, %0d accepted inputs.",
             sorts_done, answers_sent, sent);
    $display("Included idle answers, restarts while busy, saturated counts and a long hold.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
